// ----- rtl/core/sb2dec_pkg.sv -----
// Package for the signed binary to decimal ASCII converter.
// Holds the controller/datapath interface structs, FSM states and character constants.
// No dependencies.
package sb2dec_pkg;

  localparam int unsigned LEN_W      = 4;   // text_length field width
  localparam int unsigned CHAR_W     = 8;   // text_char field width
  localparam int unsigned OUT_DATA_W = 16;  // char + length, padded to whole bytes
  localparam int unsigned DIGIT_W    = 4;   // one BCD digit
  localparam int unsigned BITS_PER_STEP = 4;  // magnitude bits consumed per conversion cycle

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;  // '-'

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_TRIM,
    ST_SIGN,
    ST_DIGITS
  } sb2dec_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture input beat, clear BCD
    logic conv_step;   // shift-add-3 over one nibble of magnitude
    logic trim_step;   // drop one leading zero digit
    logic emit_sign;   // load '-' into output register
    logic emit_digit;  // load top digit into output register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic conv_last;   // final conversion step this cycle
    logic top_zero;    // leading digit is zero
    logic one_digit;   // one digit left
    logic negative;    // value is negative
    logic out_free;    // output register can take a beat
  } dp_stat_t;

endpackage

// ----- rtl/core/sb2dec_dp.sv -----
// Datapath: magnitude capture, nibble-wide double dabble, leading-zero trim
// and the output register. Depends on sb2dec_pkg.
module sb2dec_dp import sb2dec_pkg::*; #(
  parameter int unsigned INPUT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic [INPUT_BITS-1:0] number_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CHAR_W-1:0]     text_char_o,
  output logic [LEN_W-1:0]      text_length_o,
  output logic                  is_last_o
);

  localparam int unsigned MAG_W  = ((INPUT_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP)
                                   * BITS_PER_STEP;
  localparam int unsigned STEPS  = MAG_W / BITS_PER_STEP;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  // digits of the largest magnitude, 2^(INPUT_BITS-1)
  localparam int unsigned NDIG   = ((INPUT_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned NDIG_W = $clog2(NDIG + 1);
  localparam int unsigned BCD_W  = NDIG * DIGIT_W;
  localparam int unsigned SUM_W  = (NDIG_W + 1 > LEN_W) ? NDIG_W + 1 : LEN_W;

  logic                  neg_q, neg_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_step;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [NDIG_W-1:0]     ndig_q, ndig_d;
  logic [NDIG_W-1:0]     run_ndig_q, run_ndig_d;  // digits in the run, fixed once trimmed
  logic [INPUT_BITS-1:0] abs_val;
  logic [DIGIT_W-1:0]    top_digit;
  logic [SUM_W-1:0]      len_sum;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  last_q, last_d;

  // Two's complement negate; the most negative value maps onto its own
  // unsigned magnitude, so no special case is needed.
  assign abs_val   = number_i[INPUT_BITS-1] ? (~number_i + 1'b1) : number_i;
  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
  assign len_sum   = SUM_W'(run_ndig_q) + SUM_W'(neg_q);

  // Four dependent shift/add-3 steps per cycle
  always_comb begin
    bcd_step = bcd_q;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_step[d*DIGIT_W +: DIGIT_W] = bcd_step[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], mag_q[MAG_W-1-b]};
    end
  end

  always_comb begin
    neg_d       = neg_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    ndig_d      = ndig_q;
    run_ndig_d  = run_ndig_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    char_d      = char_q;
    len_d       = len_q;
    last_d      = last_q;

    if (cmd_i.load) begin
      neg_d      = number_i[INPUT_BITS-1];
      mag_d      = MAG_W'(abs_val);
      bcd_d      = '0;
      step_d     = '0;
      ndig_d     = NDIG_W'(NDIG);
      run_ndig_d = NDIG_W'(NDIG);
    end
    if (cmd_i.conv_step) begin
      mag_d  = mag_q << BITS_PER_STEP;
      bcd_d  = bcd_step;
      step_d = step_q + 1'b1;
    end
    if (cmd_i.trim_step || cmd_i.emit_digit) begin
      bcd_d  = bcd_q << DIGIT_W;
      ndig_d = ndig_q - 1'b1;
    end
    if (cmd_i.trim_step) begin
      run_ndig_d = run_ndig_q - 1'b1;
    end
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      char_d      = CHAR_MINUS;
      len_d       = len_sum[LEN_W-1:0];
      last_d      = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      char_d      = CHAR_ZERO + CHAR_W'(top_digit);
      len_d       = len_sum[LEN_W-1:0];
      last_d      = (ndig_q == NDIG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    step_q     <= step_d;
    ndig_q     <= ndig_d;
    run_ndig_q <= run_ndig_d;
    char_q     <= char_d;
    len_q      <= len_d;
    last_q     <= last_d;
  end

  assign stat_o.conv_last = (step_q == STEP_W'(STEPS - 1));
  assign stat_o.top_zero  = (top_digit == '0);
  assign stat_o.one_digit = (ndig_q == NDIG_W'(1));
  assign stat_o.negative  = neg_q;
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign text_char_o   = char_q;
  assign text_length_o = len_q;
  assign is_last_o     = last_q;

endmodule

// ----- rtl/core/sb2dec_ctrl.sv -----
// Controller FSM: sequences load, conversion, zero trim and character output.
// Depends on sb2dec_pkg.
module sb2dec_ctrl import sb2dec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  sb2dec_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_last) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (stat_i.top_zero && !stat_i.one_digit) begin
          cmd_o.trim_step = 1'b1;
        end else begin
          state_d = stat_i.negative ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (stat_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (stat_i.one_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/signed_binary_to_decimal_ascii.sv -----
// Top level of the signed binary to decimal ASCII converter.
// Instantiates sb2dec_ctrl and sb2dec_dp; depends on sb2dec_pkg.
//
//  port group   dir  bits                     contents
//  s_*          in   ceil(INPUT_BITS/8)*8     number (signed), one beat per value
//  m_*          out  16 + tlast               text_char, text_length; tlast = is_last
//
// Sequence: one beat is taken in IDLE, then the magnitude is converted by double
// dabble, four bits a cycle, then leading zero digits are dropped one at a time
// in TRIM, then the sign, if any, and the digits are sent one character at a time.
// Reset clears the FSM and the output valid flag only; data registers are not reset.
// A stall on m_tready_i holds the current character and pauses the FSM; the
// next number is taken while the last character still waits in the output register.
module signed_binary_to_decimal_ascii import sb2dec_pkg::*; #(
  parameter int unsigned INPUT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [((INPUT_BITS + 7) / 8)*8-1:0] s_tdata_i,  // [INPUT_BITS-1:0] number
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [OUT_DATA_W-1:0]               m_tdata_o,  // [7:0] text_char, [11:8] text_length
  output logic                                m_tlast_o   // is_last
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [CHAR_W-1:0]   text_char;
  logic [LEN_W-1:0]    text_length;

  sb2dec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sb2dec_dp #(
    .INPUT_BITS (INPUT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .number_i      (s_tdata_i[INPUT_BITS-1:0]),
    .out_ready_i   (m_tready_i),
    .out_valid_o   (m_tvalid_o),
    .text_char_o   (text_char),
    .text_length_o (text_length),
    .is_last_o     (m_tlast_o)
  );

  // upper tdata bits are padding
  assign m_tdata_o = {{(OUT_DATA_W - CHAR_W - LEN_W){1'b0}}, text_length, text_char};

  // A taken number blocks the input while it is converted.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input ready straight after a number was taken");

  // Only '-' or a decimal digit ever leaves the block.
  a_char_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (text_char == CHAR_MINUS) ||
                   ((text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE)))
    else $error("output character is not a sign or a digit");

  // The sign is always followed by at least one digit.
  a_sign_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (text_char == CHAR_MINUS) |-> !m_tlast_o && (text_length >= LEN_W'(2)))
    else $error("sign character marked last or run too short");

endmodule
